### sv/fipv_pkg.sv
// Package with the payload types, status codes and constants of the integer value parser.
`default_nettype none

package fipv_pkg;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic signed [63:0] int_value;
    logic [2:0]         parse_status;
  } out_t;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTrailing  = 3'd1,
    StLateSign  = 3'd2,
    StBadChar   = 3'd3,
    StNoDigit   = 3'd4,
    StMultiSign = 3'd5,
    StRange     = 3'd6
  } status_e;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // 2^63 / 10, rounded down. (2^63 - d) / 10 equals this for d up to 8.
  localparam logic [63:0] MagTenth = 64'd922337203685477580;

endpackage

`default_nettype wire

### sv/fipv_scan.sv
// Per-record scan state and the end-of-record status and value logic.
`default_nettype none

module fipv_scan #(
  parameter int RECORD_BYTES = 80,
  parameter int VALUE_START  = 10
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           step_i,
  input  wire fipv_pkg::in_t byte_i,
  output logic          done_o,
  output fipv_pkg::out_t result_o
);

  localparam int PosW = $clog2(RECORD_BYTES);
  localparam logic [PosW-1:0] PosLast = PosW'(RECORD_BYTES - 1);

  logic [PosW-1:0] pos_q;
  logic            started_q, started_d;
  logic            digit_q, digit_d;
  logic            stopped_q, stopped_d;
  logic            comment_q, comment_d;
  logic [1:0]      sign_cnt_q, sign_cnt_d;
  logic            neg_q, neg_d;
  logic [63:0]     mag_q, mag_d;
  logic [63:0]     nacc_q, nacc_d;
  logic            at_limit_q, at_limit_d;
  logic            ovf_q, ovf_d;
  logic [2:0]      err_q, err_d;

  logic        scan_en;
  logic        is_digit, is_sign, is_space;
  logic [63:0] dig;
  logic [63:0] mag_lim;
  logic [2:0]  status;

  assign is_digit = (byte_i.record_byte >= fipv_pkg::ChZero) &&
                    (byte_i.record_byte <= fipv_pkg::ChNine);
  assign is_sign  = (byte_i.record_byte == fipv_pkg::ChPlus) ||
                    (byte_i.record_byte == fipv_pkg::ChMinus);
  assign is_space = (byte_i.record_byte == fipv_pkg::ChSpace);
  assign dig      = {60'd0, byte_i.record_byte[3:0]};
  // Only a nine lowers the largest magnitude that may still take another digit.
  assign mag_lim  = (dig == 64'd9) ? (fipv_pkg::MagTenth - 64'd1) : fipv_pkg::MagTenth;

  assign scan_en = ({{(32-PosW){1'b0}}, pos_q} >= 32'(VALUE_START)) &&
                   !comment_q && (err_q == 3'(fipv_pkg::StOk));

  always_comb begin
    started_d  = started_q;
    digit_d    = digit_q;
    stopped_d  = stopped_q;
    comment_d  = comment_q;
    sign_cnt_d = sign_cnt_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    nacc_d     = nacc_q;
    at_limit_d = at_limit_q;
    ovf_d      = ovf_q;
    err_d      = err_q;
    if (scan_en) begin
      if (byte_i.record_byte == fipv_pkg::ChSlash) begin
        comment_d = 1'b1;
      end else if (!(is_space && !started_q)) begin
        started_d = 1'b1;
        if (stopped_q && !is_space) begin
          err_d = 3'(fipv_pkg::StTrailing);
        end else if (is_sign && digit_q) begin
          err_d = 3'(fipv_pkg::StLateSign);
        end else if (is_sign) begin
          if (sign_cnt_q == 2'd0) begin
            neg_d = (byte_i.record_byte == fipv_pkg::ChMinus);
          end
          if (sign_cnt_q != 2'd2) begin
            sign_cnt_d = sign_cnt_q + 2'd1;
          end
        end else if (is_digit) begin
          digit_d = 1'b1;
          if (!ovf_q) begin
            if (mag_q > mag_lim) begin
              ovf_d = 1'b1;
            end else begin
              // The negated magnitude is kept alongside so the result needs no negation.
              mag_d      = (mag_q << 3) + (mag_q << 1) + dig;
              nacc_d     = (nacc_q << 3) + (nacc_q << 1) - dig;
              at_limit_d = (dig == 64'd8) && (mag_q == fipv_pkg::MagTenth);
            end
          end
        end else if (is_space) begin
          stopped_d = 1'b1;
        end else begin
          err_d = 3'(fipv_pkg::StBadChar);
        end
      end
    end
  end

  always_comb begin
    if (err_d != 3'(fipv_pkg::StOk)) begin
      status = err_d;
    end else if (!digit_d) begin
      status = 3'(fipv_pkg::StNoDigit);
    end else if (sign_cnt_d == 2'd2) begin
      status = 3'(fipv_pkg::StMultiSign);
    end else if (ovf_d || (!neg_d && at_limit_d)) begin
      status = 3'(fipv_pkg::StRange);
    end else begin
      status = 3'(fipv_pkg::StOk);
    end
  end

  assign done_o                = byte_i.last_byte || (pos_q == PosLast);
  assign result_o.parse_status = status;
  assign result_o.int_value    = (status != 3'(fipv_pkg::StOk)) ? 64'sd0 :
                                 neg_d ? $signed(nacc_d) : $signed(mag_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      started_q  <= 1'b0;
      digit_q    <= 1'b0;
      stopped_q  <= 1'b0;
      comment_q  <= 1'b0;
      sign_cnt_q <= 2'd0;
      neg_q      <= 1'b0;
      mag_q      <= '0;
      nacc_q     <= '0;
      at_limit_q <= 1'b0;
      ovf_q      <= 1'b0;
      err_q      <= 3'(fipv_pkg::StOk);
    end else if (step_i) begin
      if (done_o) begin
        pos_q      <= '0;
        started_q  <= 1'b0;
        digit_q    <= 1'b0;
        stopped_q  <= 1'b0;
        comment_q  <= 1'b0;
        sign_cnt_q <= 2'd0;
        neg_q      <= 1'b0;
        mag_q      <= '0;
        nacc_q     <= '0;
        at_limit_q <= 1'b0;
        ovf_q      <= 1'b0;
        err_q      <= 3'(fipv_pkg::StOk);
      end else begin
        pos_q      <= pos_q + PosW'(1);
        started_q  <= started_d;
        digit_q    <= digit_d;
        stopped_q  <= stopped_d;
        comment_q  <= comment_d;
        sign_cnt_q <= sign_cnt_d;
        neg_q      <= neg_d;
        mag_q      <= mag_d;
        nacc_q     <= nacc_d;
        at_limit_q <= at_limit_d;
        ovf_q      <= ovf_d;
        err_q      <= err_d;
      end
    end
  end

  // The two accumulators must stay exact negatives of each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni) nacc_q == (64'd0 - mag_q))
    else $error("negated accumulator out of step with magnitude");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_i && done_o) |=> (pos_q == '0) && !digit_q && (err_q == 3'd0))
    else $error("record state not cleared after record end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !ovf_q |-> (mag_q <= 64'h8000_0000_0000_0000))
    else $error("magnitude beyond 2^63 without overflow");

endmodule

`default_nettype wire

### sv/fits_integer_value_parser_core.sv
// Top level of the header record integer value parser: input register, scan, result register.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | in_data_i   (record_byte, last_byte)
//   out     | output    | out_valid_o / out_stall_i| out_data_o  (int_value, parse_status)
//
// One byte per cycle is sustained while no record end waits; the scan of a byte is one shift-add step.
// The result is loaded into the result register when the record's last byte leaves the
// input register and the result register has room.
// Reset clears the record state, so the first byte after reset starts a record.
// The input side stalls only while a record-ending byte waits for a stalled result register.
`default_nettype none

module fits_integer_value_parser_core #(
  parameter int RECORD_BYTES = 80,
  parameter int VALUE_START  = 10
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wire fipv_pkg::in_t in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output fipv_pkg::out_t out_data_o
);

  logic           in_vld_q, in_vld_d;
  fipv_pkg::in_t  in_q;
  logic           out_vld_q, out_vld_d;
  fipv_pkg::out_t out_q;
  logic           advance, done;
  fipv_pkg::out_t result;

  fipv_scan #(
    .RECORD_BYTES(RECORD_BYTES),
    .VALUE_START (VALUE_START)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_q),
    .done_o  (done),
    .result_o(result)
  );

  // A byte that ends a record moves on only when the result register has room.
  assign advance    = in_vld_q && (!done || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && !in_stall_o) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance && done) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance && done) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_stall_o |-> (in_vld_q && done && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked record end");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (advance && done) |=> out_vld_q)
    else $error("record end did not load the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_vld_q && (out_q.parse_status != 3'(fipv_pkg::StOk)))
                   |-> (out_q.int_value == 64'sd0))
    else $error("nonzero value with a failing status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q |-> (out_q.parse_status <= 3'(fipv_pkg::StRange)))
    else $error("status code out of range");

endmodule

`default_nettype wire
